[rtl/core/bcc_pkg.sv]
// bcc_pkg: shared constants, codes and types of the button click classifier.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package bcc_pkg;

   // click FIFO geometry (one slot is always kept empty)
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned AVAIL_W    = 3;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned CLICK_W = 2;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned CSR_IDX_W = 3;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_WAIT     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_BOUNCE   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PREP     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_WAIT_REP = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LOOP_REP = 3'd4;
   localparam logic [PHASE_W-1:0] PH_ENDLESS  = 3'd5;

   // click codes
   localparam logic [CLICK_W-1:0] CLK_NONE   = 2'd0;
   localparam logic [CLICK_W-1:0] CLK_NORMAL = 2'd1;
   localparam logic [CLICK_W-1:0] CLK_DOUBLE = 2'd2;
   localparam logic [CLICK_W-1:0] CLK_HOLD   = 2'd3;

   // item actions
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNCE_DELAY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_DELAY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MODE   = 3'd4;

   // register reset values
   localparam logic [DELAY_W-1:0] RST_BOUNCE_DELAY  = 16'd25;
   localparam logic [DELAY_W-1:0] RST_DOUBLE_DELAY  = 16'd250;
   localparam logic [DELAY_W-1:0] RST_REPEAT_DELAY  = 16'd500;
   localparam logic [DELAY_W-1:0] RST_REPEAT_PERIOD = 16'd100;
   localparam logic               RST_REPEAT_MODE   = 1'b0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [DELAY_W-1:0] bounce_delay;
      logic [DELAY_W-1:0] double_delay;
      logic [DELAY_W-1:0] repeat_delay;
      logic [DELAY_W-1:0] repeat_period;
      logic               repeat_mode;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [CLICK_W-1:0] code;
   } push_type;

   typedef struct packed {
      logic [CLICK_W-1:0] data;
      logic [AVAIL_W-1:0] avail;
   } fifo_status_type;

endpackage

`default_nettype wire

[rtl/core/bcc_fsm.sv]
// bcc_fsm: debounce / double-click / hold-or-repeat phase machine.
// Depends on bcc_pkg; emits at most one click push per sample beat.
`default_nettype none

module bcc_fsm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          sample_en,
   input  wire logic                          pressed,
   input  wire logic [bcc_pkg::TIME_W-1:0]    now_ms,
   input  wire bcc_pkg::cfg_type              cfg,
   output bcc_pkg::push_type                  push
);

   logic [bcc_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [bcc_pkg::TIME_W-1:0]  stamp_ff, stamp_in;
   logic [bcc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bcc_pkg::TIME_W-1:0]  dt;
   logic gt_bounce, gt_double, gt_rep_delay, gt_rep_period;

   // elapsed time wraps modulo 2^32
   assign dt            = now_ms - stamp_ff;
   assign gt_bounce     = dt > {16'h0000, cfg.bounce_delay};
   assign gt_double     = dt > {16'h0000, cfg.double_delay};
   assign gt_rep_delay  = dt > {16'h0000, cfg.repeat_delay};
   assign gt_rep_period = dt > {16'h0000, cfg.repeat_period};

   always_comb begin
      phase_in   = phase_ff;
      stamp_in   = stamp_ff;
      count_in   = count_ff;
      push.valid = 1'b0;
      push.code  = bcc_pkg::CLK_NORMAL;
      if (sample_en) begin
         if (pressed) begin
            case (phase_ff)
               bcc_pkg::PH_WAIT: begin
                  stamp_in = now_ms;
                  if (count_ff != bcc_pkg::COUNT_MAX) begin
                     count_in = count_ff + 8'd1;
                  end
                  phase_in = bcc_pkg::PH_BOUNCE;
               end
               bcc_pkg::PH_BOUNCE: begin
                  if (gt_bounce) begin
                     phase_in = bcc_pkg::PH_PREP;
                  end
               end
               bcc_pkg::PH_PREP: begin
                  if (gt_double) begin
                     count_in   = '0;
                     push.valid = 1'b1;
                     if (cfg.repeat_mode) begin
                        push.code = bcc_pkg::CLK_NORMAL;
                        phase_in  = bcc_pkg::PH_WAIT_REP;
                     end else begin
                        push.code = bcc_pkg::CLK_HOLD;
                        phase_in  = bcc_pkg::PH_ENDLESS;
                     end
                  end
               end
               bcc_pkg::PH_WAIT_REP: begin
                  if (gt_rep_delay) begin
                     phase_in = bcc_pkg::PH_LOOP_REP;
                  end
               end
               bcc_pkg::PH_LOOP_REP: begin
                  if (gt_rep_period) begin
                     push.valid = 1'b1;
                     push.code  = bcc_pkg::CLK_NORMAL;
                     stamp_in   = now_ms;
                  end
               end
               default: begin
               end
            endcase
         end else if (phase_ff != bcc_pkg::PH_BOUNCE) begin
            // release outside debounce: flush a pending click once the window passed
            if (count_ff != '0 && gt_double) begin
               push.valid = 1'b1;
               push.code  = (count_ff == 8'd1) ? bcc_pkg::CLK_NORMAL : bcc_pkg::CLK_DOUBLE;
               count_in   = '0;
            end
            phase_in = bcc_pkg::PH_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bcc_pkg::PH_WAIT;
         stamp_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         stamp_ff <= stamp_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/bcc_fifo.sv]
// bcc_fifo: ring FIFO of clicks that keeps one slot empty; drops pushes when full.
// Depends on bcc_pkg; pop data and the post-beat fill level are combinational.
`default_nettype none

module bcc_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bcc_pkg::push_type    push,
   input  wire logic                 pop,
   output bcc_pkg::fifo_status_type  status
);

   localparam int unsigned PW = bcc_pkg::PTR_W;
   localparam logic [PW-1:0] LAST_SLOT = PW'(bcc_pkg::FIFO_DEPTH - 1);
   localparam logic [PW:0]   DEPTH_X   = (PW+1)'(bcc_pkg::FIFO_DEPTH);

   logic [bcc_pkg::CLICK_W-1:0] click_store [bcc_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] count_cur, count_nxt;
   logic          do_push, do_pop, empty;
   logic [bcc_pkg::AVAIL_W+PW-1:0] count_ext;

   function automatic logic [PW-1:0] fill(input logic [PW-1:0] wr, input logic [PW-1:0] rd);
      logic [PW:0] diff;
      if (wr >= rd) begin
         diff = {1'b0, wr} - {1'b0, rd};
      end else begin
         diff = {1'b0, wr} + DEPTH_X - {1'b0, rd};
      end
      return diff[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + PW'(1);
   endfunction

   assign count_cur = fill(wr_ptr_ff, rd_ptr_ff);
   assign empty     = count_cur == '0;
   assign do_push   = push.valid && (count_cur != LAST_SLOT);
   assign do_pop    = pop && !empty;
   assign wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
   assign count_nxt = fill(wr_ptr_in, rd_ptr_in);
   assign count_ext = {{bcc_pkg::AVAIL_W{1'b0}}, count_nxt};

   assign status.data  = do_pop ? click_store[rd_ptr_ff] : bcc_pkg::CLK_NONE;
   assign status.avail = count_ext[bcc_pkg::AVAIL_W-1:0];

   always_ff @(posedge clock) begin
      if (do_push) begin
         click_store[wr_ptr_ff] <= push.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/button_click_classifier.sv]
// button_click_classifier: a req beat reaches rsp_valid through the input register,
// then the result register; one item per cycle sustained while rsp_ready stays high.
// Ready from the result side passes combinationally back to req_ready.
// Synchronous active-high reset clears both stage valids, the phase machine,
// FIFO pointers, last value and loads the register defaults. csr_ready is always high.
`default_nettype none

module button_click_classifier (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic                              req_pressed,
   input  wire logic [bcc_pkg::TIME_W-1:0]        req_now_ms,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bcc_pkg::CLICK_W-1:0]            rsp_click,
   output logic [bcc_pkg::AVAIL_W-1:0]            rsp_available,
   output logic [bcc_pkg::CLICK_W-1:0]            rsp_last_click,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bcc_pkg::DELAY_W-1:0]       csr_wdata
);

   bcc_pkg::cfg_type cfg_ff, cfg_in;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_action_ff;
   logic                        s1_pressed_ff;
   logic [bcc_pkg::TIME_W-1:0]  s1_now_ff;

   logic                        out_valid_ff, out_valid_in;
   logic [bcc_pkg::CLICK_W-1:0] out_click_ff;
   logic [bcc_pkg::AVAIL_W-1:0] out_avail_ff;
   logic [bcc_pkg::CLICK_W-1:0] out_last_ff;
   logic [bcc_pkg::CLICK_W-1:0] last_value_ff, last_value_in;

   logic advance, take;
   bcc_pkg::push_type         push;
   bcc_pkg::fifo_status_type  fstat;

   // ---- register file ----
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bcc_pkg::CSR_BOUNCE_DELAY:  cfg_in.bounce_delay  = csr_wdata;
            bcc_pkg::CSR_DOUBLE_DELAY:  cfg_in.double_delay  = csr_wdata;
            bcc_pkg::CSR_REPEAT_DELAY:  cfg_in.repeat_delay  = csr_wdata;
            bcc_pkg::CSR_REPEAT_PERIOD: cfg_in.repeat_period = csr_wdata;
            bcc_pkg::CSR_REPEAT_MODE:   cfg_in.repeat_mode   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ---- handshake ----
   assign advance     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign take        = req_valid && req_ready;
   assign s1_valid_in = take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   bcc_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .sample_en (advance && (s1_action_ff == bcc_pkg::ACT_SAMPLE)),
      .pressed   (s1_pressed_ff),
      .now_ms    (s1_now_ff),
      .cfg       (cfg_ff),
      .push      (push)
   );

   bcc_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (advance && (s1_action_ff == bcc_pkg::ACT_READ)),
      .status (fstat)
   );

   // a read beat records whatever it returned, including none on empty
   assign last_value_in = (advance && (s1_action_ff == bcc_pkg::ACT_READ)) ?
                          fstat.data : last_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounce_delay  <= bcc_pkg::RST_BOUNCE_DELAY;
         cfg_ff.double_delay  <= bcc_pkg::RST_DOUBLE_DELAY;
         cfg_ff.repeat_delay  <= bcc_pkg::RST_REPEAT_DELAY;
         cfg_ff.repeat_period <= bcc_pkg::RST_REPEAT_PERIOD;
         cfg_ff.repeat_mode   <= bcc_pkg::RST_REPEAT_MODE;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         last_value_ff <= bcc_pkg::CLK_NONE;
      end else begin
         cfg_ff        <= cfg_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         last_value_ff <= last_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_action_ff  <= req_action;
         s1_pressed_ff <= req_pressed;
         s1_now_ff     <= req_now_ms;
      end
      if (advance) begin
         out_click_ff <= fstat.data;
         out_avail_ff <= fstat.avail;
         out_last_ff  <= last_value_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_click      = out_click_ff;
   assign rsp_available  = out_avail_ff;
   assign rsp_last_click = out_last_ff;

endmodule

`default_nettype wire

[rtl/core/bcc_checker.sv]
// bcc_checker: port-level checks of button_click_classifier, bound to the top level.
// Depends on bcc_pkg for field widths and click codes.
`default_nettype none

module bcc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [bcc_pkg::CLICK_W-1:0]    rsp_click,
   input wire logic [bcc_pkg::AVAIL_W-1:0]    rsp_available,
   input wire logic [bcc_pkg::CLICK_W-1:0]    rsp_last_click
);

   // result beat held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_click) && $stable(rsp_available)
                                  && $stable(rsp_last_click))
      else $error("rsp payload changed while stalled");

   // only a read returns a click, and a read always records it as the last value
   a_click_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_click != bcc_pkg::CLK_NONE) |-> rsp_last_click == rsp_click)
      else $error("popped click not recorded as last value");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_click      (rsp_click),
   .rsp_available  (rsp_available),
   .rsp_last_click (rsp_last_click)
);

`default_nettype wire
